@@ src/csi_pkg.sv @@
// Shared constants for the crossing sign and intersection block.
`default_nettype none

package csi_pkg;

    // Default coordinate width in bits (signed fixed point, Q8.8 by default)
    localparam int COORD_WIDTH_DEFAULT = 16;

endpackage : csi_pkg

`default_nettype wire

@@ src/crossing_sign_and_intersection.sv @@
// Pipelined crossing sign and line intersection unit with a restoring divider.
// start passes the difference, product, cross product, partial product and seed stages;
// the divider runs one quotient bit per pipeline stage, COORD_WIDTH + 1 stages.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset: rst_n asynchronous active low clears every valid bit; payload is not reset.
// Scaling: the fraction bits cancel in the quotient, so the point comes out rounded in the inputs' own Q format.
`default_nettype none

module crossing_sign_and_intersection
    import csi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] over_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] over_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] over_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] over_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] under_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] under_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] under_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] under_end_y,
    output logic                               done,
    output logic                               positive_crossing,
    output logic signed [COORD_WIDTH-1:0]      meet_x,
    output logic signed [COORD_WIDTH-1:0]      meet_y,
    output logic                               lines_parallel,
    output logic                               point_overflow
);

    localparam int W   = COORD_WIDTH;
    localparam int DFW = W + 1;          // coordinate difference
    localparam int PW  = 2 * W + 2;      // signed product of two differences
    localparam int XW  = 2 * W + 3;      // signed cross product
    localparam int MW  = 2 * W + 2;      // cross product magnitude
    localparam int RW  = W + 1;          // direction component magnitude
    localparam int LW  = W + 1;          // low chunk of the numerator magnitude
    localparam int PPW = LW + RW;        // partial product width
    localparam int NW  = 3 * W + 4;      // dividend width
    localparam int QW  = W + 1;          // quotient bits computed
    localparam int SW  = W + 3;          // signed width of base plus offset

    typedef struct packed {
        logic                turn_neg;
        logic                par;
        logic                neg_x;
        logic                neg_y;
        logic                big_x;
        logic                big_y;
        logic signed [W-1:0] base_x;
        logic signed [W-1:0] base_y;
        logic [MW-1:0]       den;
    } div_side_t;

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences
    // ------------------------------------------------------------------
    logic                  v1_reg;
    logic signed [W-1:0]   base_x1_reg, base_y1_reg;
    logic signed [DFW-1:0] rx1_reg, ry1_reg, sx1_reg, sy1_reg;
    logic signed [DFW-1:0] ax1_reg, ay1_reg, tx1_reg, ty1_reg, ux1_reg, uy1_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x1_reg <= over_end_x;
        base_y1_reg <= over_end_y;
        rx1_reg <= DFW'(over_start_x) - DFW'(over_end_x);
        ry1_reg <= DFW'(over_start_y) - DFW'(over_end_y);
        sx1_reg <= DFW'(under_end_x) - DFW'(under_start_x);
        sy1_reg <= DFW'(under_end_y) - DFW'(under_start_y);
        ax1_reg <= DFW'(under_start_x) - DFW'(over_end_x);
        ay1_reg <= DFW'(under_start_y) - DFW'(over_end_y);
        tx1_reg <= DFW'(over_end_x) - DFW'(over_start_x);
        ty1_reg <= DFW'(over_end_y) - DFW'(over_start_y);
        ux1_reg <= DFW'(under_start_x) - DFW'(over_start_x);
        uy1_reg <= DFW'(under_start_y) - DFW'(over_start_y);
    end

    // ------------------------------------------------------------------
    // Stage 2: products for the three cross products
    // ------------------------------------------------------------------
    logic                  v2_reg;
    logic signed [W-1:0]   base_x2_reg, base_y2_reg;
    logic signed [DFW-1:0] rx2_reg, ry2_reg;
    logic signed [PW-1:0]  pd1_reg, pd2_reg, pn1_reg, pn2_reg, pt1_reg, pt2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x2_reg <= base_x1_reg;
        base_y2_reg <= base_y1_reg;
        rx2_reg <= rx1_reg;
        ry2_reg <= ry1_reg;
        pd1_reg <= PW'(rx1_reg) * PW'(sy1_reg);
        pd2_reg <= PW'(ry1_reg) * PW'(sx1_reg);
        pn1_reg <= PW'(ax1_reg) * PW'(sy1_reg);
        pn2_reg <= PW'(ay1_reg) * PW'(sx1_reg);
        pt1_reg <= PW'(tx1_reg) * PW'(uy1_reg);
        pt2_reg <= PW'(ty1_reg) * PW'(ux1_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products, reduced to magnitude and sign
    // ------------------------------------------------------------------
    logic signed [XW-1:0] den3, num3, turn3;
    logic                 v3_reg;
    logic signed [W-1:0]  base_x3_reg, base_y3_reg;
    logic [MW-1:0]        den3_reg, num3_reg;
    logic [RW-1:0]        rmx3_reg, rmy3_reg;
    logic                 negx3_reg, negy3_reg, turn3_reg, par3_reg;

    always_comb
    begin
        den3  = XW'(pd1_reg) - XW'(pd2_reg);
        num3  = XW'(pn1_reg) - XW'(pn2_reg);
        turn3 = XW'(pt1_reg) - XW'(pt2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x3_reg <= base_x2_reg;
        base_y3_reg <= base_y2_reg;
        den3_reg    <= den3[XW-1] ? MW'(-den3) : MW'(den3);
        num3_reg    <= num3[XW-1] ? MW'(-num3) : MW'(num3);
        rmx3_reg    <= rx2_reg[DFW-1] ? RW'(-rx2_reg) : RW'(rx2_reg);
        rmy3_reg    <= ry2_reg[DFW-1] ? RW'(-ry2_reg) : RW'(ry2_reg);
        negx3_reg   <= num3[XW-1] ^ rx2_reg[DFW-1] ^ den3[XW-1];
        negy3_reg   <= num3[XW-1] ^ ry2_reg[DFW-1] ^ den3[XW-1];
        turn3_reg   <= turn3[XW-1];
        par3_reg    <= (den3 == '0);
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of numerator times direction
    // ------------------------------------------------------------------
    logic                v4_reg;
    logic [PPW-1:0]      plx4_reg, phx4_reg, ply4_reg, phy4_reg;
    logic signed [W-1:0] base_x4_reg, base_y4_reg;
    logic [MW-1:0]       den4_reg;
    logic                negx4_reg, negy4_reg, turn4_reg, par4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plx4_reg    <= PPW'(num3_reg[LW-1:0]) * PPW'(rmx3_reg);
        phx4_reg    <= PPW'(num3_reg[MW-1:LW]) * PPW'(rmx3_reg);
        ply4_reg    <= PPW'(num3_reg[LW-1:0]) * PPW'(rmy3_reg);
        phy4_reg    <= PPW'(num3_reg[MW-1:LW]) * PPW'(rmy3_reg);
        base_x4_reg <= base_x3_reg;
        base_y4_reg <= base_y3_reg;
        den4_reg    <= den3_reg;
        negx4_reg   <= negx3_reg;
        negy4_reg   <= negy3_reg;
        turn4_reg   <= turn3_reg;
        par4_reg    <= par3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: rounded dividend, range check and divider seed
    // ------------------------------------------------------------------
    logic [NW-1:0] nx5, ny5;
    logic          bigx5, bigy5;

    always_comb
    begin
        nx5 = (NW'(phx4_reg) << LW) + NW'(plx4_reg) + NW'(den4_reg >> 1);
        ny5 = (NW'(phy4_reg) << LW) + NW'(ply4_reg) + NW'(den4_reg >> 1);
        bigx5 = (nx5[NW-1:QW] >= (NW-QW)'(den4_reg));
        bigy5 = (ny5[NW-1:QW] >= (NW-QW)'(den4_reg));
    end

    logic            div_valid_reg [0:QW];
    div_side_t       div_side_reg  [0:QW];
    logic [MW-1:0]   rem_x_reg     [0:QW];
    logic [MW-1:0]   rem_y_reg     [0:QW];
    logic [QW-1:0]   qn_x_reg      [0:QW];
    logic [QW-1:0]   qn_y_reg      [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else
        begin
            div_valid_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_side_reg[0].turn_neg <= turn4_reg;
        div_side_reg[0].par      <= par4_reg;
        div_side_reg[0].neg_x    <= negx4_reg;
        div_side_reg[0].neg_y    <= negy4_reg;
        div_side_reg[0].big_x    <= bigx5;
        div_side_reg[0].big_y    <= bigy5;
        div_side_reg[0].base_x   <= base_x4_reg;
        div_side_reg[0].base_y   <= base_y4_reg;
        div_side_reg[0].den      <= den4_reg;
        rem_x_reg[0] <= MW'(nx5[NW-1:QW]);
        rem_y_reg[0] <= MW'(ny5[NW-1:QW]);
        qn_x_reg[0]  <= nx5[QW-1:0];
        qn_y_reg[0]  <= ny5[QW-1:0];
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage, quotient shifts in at the bottom
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [MW:0] trial_x, trial_y;
        logic        ge_x, ge_y;

        always_comb
        begin
            trial_x = {rem_x_reg[k], qn_x_reg[k][QW-1]};
            trial_y = {rem_y_reg[k], qn_y_reg[k][QW-1]};
            ge_x = (trial_x >= {1'b0, div_side_reg[k].den});
            ge_y = (trial_y >= {1'b0, div_side_reg[k].den});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_side_reg[k+1] <= div_side_reg[k];
            rem_x_reg[k+1] <= ge_x ? MW'(trial_x - {1'b0, div_side_reg[k].den}) : MW'(trial_x);
            rem_y_reg[k+1] <= ge_y ? MW'(trial_y - {1'b0, div_side_reg[k].den}) : MW'(trial_y);
            qn_x_reg[k+1]  <= {qn_x_reg[k][QW-2:0], ge_x};
            qn_y_reg[k+1]  <= {qn_y_reg[k][QW-2:0], ge_y};
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add offset to base, saturate, drive the result
    // ------------------------------------------------------------------
    localparam logic signed [SW-1:0] MAXV = SW'((1 << (W - 1)) - 1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    div_side_t            fin;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [W-1:0]  px, py;
    logic                 ovx, ovy;

    always_comb
    begin
        fin = div_side_reg[QW];
        sum_x = fin.neg_x ? SW'(fin.base_x) - SW'(qn_x_reg[QW])
                          : SW'(fin.base_x) + SW'(qn_x_reg[QW]);
        sum_y = fin.neg_y ? SW'(fin.base_y) - SW'(qn_y_reg[QW])
                          : SW'(fin.base_y) + SW'(qn_y_reg[QW]);
        ovx = 1'b1;
        if (fin.big_x)
        begin
            px = fin.neg_x ? W'(MINV) : W'(MAXV);
        end
        else if (sum_x > MAXV)
        begin
            px = W'(MAXV);
        end
        else if (sum_x < MINV)
        begin
            px = W'(MINV);
        end
        else
        begin
            px  = W'(sum_x);
            ovx = 1'b0;
        end
        ovy = 1'b1;
        if (fin.big_y)
        begin
            py = fin.neg_y ? W'(MINV) : W'(MAXV);
        end
        else if (sum_y > MAXV)
        begin
            py = W'(MAXV);
        end
        else if (sum_y < MINV)
        begin
            py = W'(MINV);
        end
        else
        begin
            py  = W'(sum_y);
            ovy = 1'b0;
        end
    end

    logic                done_reg;
    logic                positive_crossing_reg, lines_parallel_reg, point_overflow_reg;
    logic signed [W-1:0] meet_x_reg, meet_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        positive_crossing_reg <= fin.turn_neg;
        lines_parallel_reg    <= fin.par;
        meet_x_reg            <= fin.par ? '0 : px;
        meet_y_reg            <= fin.par ? '0 : py;
        point_overflow_reg    <= !fin.par && (ovx || ovy);
    end

    assign done              = done_reg;
    assign positive_crossing = positive_crossing_reg;
    assign meet_x            = meet_x_reg;
    assign meet_y            = meet_y_reg;
    assign lines_parallel    = lines_parallel_reg;
    assign point_overflow    = point_overflow_reg;

endmodule : crossing_sign_and_intersection

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the crossing sign and intersection unit.
`default_nettype none

module tb
    import csi_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = COORD_WIDTH_DEFAULT;
    localparam int N_RANDOM   = 450;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = CW + 20;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t o1x, o1y, o2x, o2y, u1x, u1y, u2x, u2y;
    } crossing_t;

    typedef struct packed {
        logic   positive;
        coord_t mx, my;
        logic   parallel;
        logic   ovf;
    } meet_t;

    typedef struct packed {
        crossing_t c;
        logic      typed;
        meet_t     m;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    crossing_t cur = '0;
    logic cur_typed = 1'b0;
    meet_t cur_meet = '0;
    logic done, positive_crossing, lines_parallel, point_overflow;
    coord_t meet_x, meet_y;

    meet_t pending_meets[$];
    int errors = 0;
    int idle_cycles = 0;

    crossing_sign_and_intersection dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .over_start_x(cur.o1x), .over_start_y(cur.o1y),
        .over_end_x(cur.o2x), .over_end_y(cur.o2y),
        .under_start_x(cur.u1x), .under_start_y(cur.u1y),
        .under_end_x(cur.u2x), .under_end_y(cur.u2y),
        .done(done), .positive_crossing(positive_crossing),
        .meet_x(meet_x), .meet_y(meet_y),
        .lines_parallel(lines_parallel), .point_overflow(point_overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // base + round(num * rv / den), ties away from zero, then saturate
    function automatic coord_t place_coord(longint base, longint num, longint rv,
                                           longint den, inout logic ovf);
        longint prod, mag, dmag, q, v, maxv, minv;
        logic neg;
        maxv = (longint'(1) <<< (CW - 1)) - 1;
        minv = -maxv - 1;
        prod = num * rv;
        mag  = prod < 0 ? -prod : prod;
        dmag = den < 0 ? -den : den;
        q    = (mag + dmag / 2) / dmag;
        neg  = (prod < 0) != (den < 0);
        v    = neg ? base - q : base + q;
        if (v > maxv)
        begin
            ovf = 1'b1;
            v = maxv;
        end
        else if (v < minv)
        begin
            ovf = 1'b1;
            v = minv;
        end
        return coord_t'(v);
    endfunction

    function automatic meet_t predict_meet(crossing_t c);
        longint o1x, o1y, o2x, o2y, u1x, u1y, u2x, u2y;
        longint turn, rx, ry, sx, sy, den, num;
        meet_t m;
        o1x = c.o1x; o1y = c.o1y; o2x = c.o2x; o2y = c.o2y;
        u1x = c.u1x; u1y = c.u1y; u2x = c.u2x; u2y = c.u2y;
        turn = (o2x - o1x) * (u1y - o1y) - (o2y - o1y) * (u1x - o1x);
        rx = o1x - o2x; ry = o1y - o2y;
        sx = u2x - u1x; sy = u2y - u1y;
        den = rx * sy - ry * sx;
        num = (u1x - o2x) * sy - (u1y - o2y) * sx;
        m = '0;
        m.positive = turn < 0;
        m.parallel = den == 0;
        if (den != 0)
        begin
            m.mx = place_coord(o2x, num, rx, den, m.ovf);
            m.my = place_coord(o2y, num, ry, den, m.ovf);
        end
        return m;
    endfunction

    // Record each accepted transaction, check each result, run the watchdog
    always @(posedge clk)
    begin
        meet_t want;
        logic moved;
        moved = 1'b0;
        if (start && !busy)
        begin
            pending_meets.push_back(cur_typed ? cur_meet : predict_meet(cur));
            moved = 1'b1;
        end
        if (done)
        begin
            moved = 1'b1;
            if (pending_meets.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, meet_x, meet_y);
                errors++;
            end
            else
            begin
                want = pending_meets.pop_front();
                if (positive_crossing !== want.positive)
                begin
                    $display("%0t: positive_crossing expected %0b actual %0b",
                             $time, want.positive, positive_crossing);
                    errors++;
                end
                if (meet_x !== want.mx)
                begin
                    $display("%0t: meet_x expected %0d actual %0d", $time, want.mx, meet_x);
                    errors++;
                end
                if (meet_y !== want.my)
                begin
                    $display("%0t: meet_y expected %0d actual %0d", $time, want.my, meet_y);
                    errors++;
                end
                if (lines_parallel !== want.parallel)
                begin
                    $display("%0t: lines_parallel expected %0b actual %0b",
                             $time, want.parallel, lines_parallel);
                    errors++;
                end
                if (point_overflow !== want.ovf)
                begin
                    $display("%0t: point_overflow expected %0b actual %0b",
                             $time, want.ovf, point_overflow);
                    errors++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Hold one crossing on the ports until it is taken
    task automatic send_crossing(row_t r, logic may_idle);
        logic taken;
        while (may_idle && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        cur       <= r.c;
        cur_typed <= r.typed;
        cur_meet  <= r.m;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    function automatic coord_t rand_coord(int span);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    function automatic crossing_t random_crossing();
        crossing_t c;
        int kind, span;
        kind = $urandom_range(9);
        span = kind < 6 ? 2048 : (1 << (CW - 1)) - 1;
        c = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
             rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
        if (kind == 9)
            c = crossing_t'({$urandom, $urandom, $urandom, $urandom});
        // parallel: under strand runs along a multiple of the over direction
        if (kind == 7)
        begin
            c.o1x = rand_coord(1000); c.o1y = rand_coord(1000);
            c.o2x = c.o1x + rand_coord(100); c.o2y = c.o1y + rand_coord(100);
            c.u2x = c.u1x + 3 * (c.o2x - c.o1x);
            c.u2y = c.u1y + 3 * (c.o2y - c.o1y);
        end
        // degenerate: zero-length strand
        if (kind == 8)
        begin
            c.u2x = c.u1x;
            c.u2y = c.u1y;
        end
        return c;
    endfunction

    row_t directed[] = '{
        // all zero: degenerate, parallel
        '{c: '0, typed: 1'b1, m: '{1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
        // plain crossing, under strand going up
        '{c: '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd128, -16'sd128, 16'sd128, 16'sd128},
          typed: 1'b1, m: '{1'b1, 16'sd128, 16'sd0, 1'b0, 1'b0}},
        // same crossing, under strand going down
        '{c: '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd128, 16'sd128, 16'sd128, -16'sd128},
          typed: 1'b1, m: '{1'b0, 16'sd128, 16'sd0, 1'b0, 1'b0}},
        // zero-length over strand
        '{c: '{16'sd5, 16'sd7, 16'sd5, 16'sd7, 16'sd1, 16'sd2, 16'sd3, 16'sd4},
          typed: 1'b1, m: '{1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
        // extremes of the range
        '{c: '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
               -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, typed: 1'b0, m: '0},
        '{c: '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
               16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, typed: 1'b0, m: '0},
        // nearly parallel lines meeting far out
        '{c: '{16'sd0, 16'sd0, 16'sd1000, 16'sd1, 16'sd0, 16'sd10, 16'sd1000, 16'sd12},
          typed: 1'b0, m: '0},
        '{c: '{16'sd0, 16'sd0, -16'sd1000, 16'sd1, 16'sd0, 16'sd10, -16'sd1000, 16'sd12},
          typed: 1'b0, m: '0},
        '{c: '{16'sd0, 16'sd0, 16'sd1, -16'sd1000, 16'sd10, 16'sd0, 16'sd12, -16'sd1000},
          typed: 1'b0, m: '0},
        // rounding ties in both directions
        '{c: '{16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd1},
          typed: 1'b0, m: '0},
        '{c: '{16'sd0, 16'sd0, -16'sd3, 16'sd0, -16'sd1, -16'sd1, -16'sd2, 16'sd1},
          typed: 1'b0, m: '0},
        // collinear strands
        '{c: '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd20, 16'sd20, 16'sd30, 16'sd30},
          typed: 1'b1, m: '{1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{c: '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
          typed: 1'b1, m: '{1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0}}
    };

    initial
    begin
        row_t r;
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table back to back
        foreach (directed[i])
            send_crossing(directed[i], 1'b0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // let the pipeline empty once before going on
            if (n == 300)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_meets.size() != 0)
                    @(posedge clk);
            end
            r = '0;
            r.c = random_crossing();
            send_crossing(r, !(n >= 150 && n < 250));
        end
        start <= 1'b0;

        // drain the pipeline
        waited = 0;
        while (pending_meets.size() != 0 && waited < IDLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && pending_meets.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : tb

`default_nettype wire
